### hdl/bbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

    // Input transaction
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic balanced;
        logic overflowed;
    } out_item_t;

    // Bracket characters
    localparam logic [7:0] CHAR_LPAREN = 8'h28;  // (
    localparam logic [7:0] CHAR_RPAREN = 8'h29;  // )
    localparam logic [7:0] CHAR_LSQ    = 8'h5B;  // [
    localparam logic [7:0] CHAR_RSQ    = 8'h5D;  // ]
    localparam logic [7:0] CHAR_LCURLY = 8'h7B;  // {
    localparam logic [7:0] CHAR_RCURLY = 8'h7D;  // }

    // Bracket kind codes held on the stack
    localparam logic [1:0] BR_PAREN  = 2'd0;
    localparam logic [1:0] BR_SQUARE = 2'd1;
    localparam logic [1:0] BR_CURLY  = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } op_t;

    // Classified command, front to back
    typedef struct packed {
        op_t        op;
        logic [1:0] code;
        logic       last;
    } cmd_t;

    localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

### hdl/bbc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/bbc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bbc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire bbc_pkg::in_item_t  in_data,
    output      logic               cmd_valid,
    input  wire logic               cmd_ready,
    output      bbc_pkg::cmd_t      cmd
);

    import bbc_pkg::*;

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;
    logic load;

    assign in_stall  = valid_reg && !cmd_ready;
    assign load      = in_valid && !in_stall;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    // classify the byte
    always_comb
    begin
        cmd_next      = cmd_reg;
        valid_next    = valid_reg;
        if (load)
        begin
            valid_next    = 1'b1;
            cmd_next.last = in_data.last_char;
            cmd_next.op   = OP_NONE;
            cmd_next.code = BR_PAREN;
            unique case (in_data.char_code)
                CHAR_LPAREN: begin cmd_next.op = OP_PUSH; cmd_next.code = BR_PAREN;  end
                CHAR_LSQ:    begin cmd_next.op = OP_PUSH; cmd_next.code = BR_SQUARE; end
                CHAR_LCURLY: begin cmd_next.op = OP_PUSH; cmd_next.code = BR_CURLY;  end
                CHAR_RPAREN: begin cmd_next.op = OP_POP;  cmd_next.code = BR_PAREN;  end
                CHAR_RSQ:    begin cmd_next.op = OP_POP;  cmd_next.code = BR_SQUARE; end
                CHAR_RCURLY: begin cmd_next.op = OP_POP;  cmd_next.code = BR_CURLY;  end
                default:     begin cmd_next.op = OP_NONE; end
            endcase
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

### hdl/bbc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bbc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output      logic          push_ready,
    input  wire bbc_pkg::cmd_t push_cmd,
    output      logic          pop_valid,
    input  wire logic          pop_ready,
    output      bbc_pkg::cmd_t pop_cmd
);

    import bbc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_pop     = pop_valid && pop_ready;
    // a full queue still takes a transaction in a cycle that drains one
    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH)) || do_pop;
    assign do_push    = push_valid && push_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

### hdl/bbc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bbc_back #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output      logic               cmd_ready,
    input  wire bbc_pkg::cmd_t      cmd,
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      bbc_pkg::out_item_t out_data
);

    import bbc_pkg::*;

    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    // Top two entries live in registers; the RAM holds everything below.
    logic [LVL_W-1:0] level_reg, level_next;
    logic             mis_reg, mis_next;
    logic             ovf_reg, ovf_next;
    logic [1:0]       t0_reg, t0_next;
    logic [1:0]       t1_reg, t1_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    logic              take;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [1:0]        ram_wdata, ram_rdata;
    logic [LVL_W-1:0]  raddr_full;
    logic              fwd_reg;
    logic [1:0]        fwd_data_reg;
    logic [1:0]        below;

    assign cmd_ready = !out_valid_reg || !out_stall;
    assign take      = cmd_valid && cmd_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // third entry from the top, with write-to-read bypass
    assign below = fwd_reg ? fwd_data_reg : ram_rdata;

    always_comb
    begin
        level_next     = level_reg;
        mis_next       = mis_reg;
        ovf_next       = ovf_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_we         = 1'b0;
        ram_waddr      = ADDR_W'(level_reg - LVL_W'(2));
        ram_wdata      = t1_reg;
        if (take)
        begin
            if (!mis_reg)
            begin
                unique case (cmd.op)
                    OP_PUSH:
                    begin
                        if (level_reg == LVL_W'(STACK_DEPTH))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            ram_we     = (level_reg >= LVL_W'(2));
                            t1_next    = t0_reg;
                            t0_next    = cmd.code;
                            level_next = level_reg + LVL_W'(1);
                        end
                    end
                    OP_POP:
                    begin
                        if (level_reg == '0 || t0_reg != cmd.code)
                        begin
                            mis_next = 1'b1;
                        end
                        else
                        begin
                            t0_next    = t1_reg;
                            t1_next    = below;
                            level_next = level_reg - LVL_W'(1);
                        end
                    end
                    OP_NONE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.last)
            begin
                out_valid_next      = 1'b1;
                out_next.balanced   = !mis_next && !ovf_next && (level_next == '0);
                out_next.overflowed = ovf_next;
                level_next          = '0;
                mis_next            = 1'b0;
                ovf_next            = 1'b0;
            end
        end
        // fetch the entry that a pop next cycle would need
        raddr_full = level_next - LVL_W'(3);
        ram_raddr  = raddr_full[ADDR_W-1:0];
    end

    bbc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            mis_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            mis_reg       <= mis_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            fwd_reg       <= ram_we && (ram_waddr == ram_raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        t0_reg       <= t0_next;
        t1_reg       <= t1_next;
        out_reg      <= out_next;
        fwd_data_reg <= ram_wdata;
    end

`ifndef SYNTH
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cmd.last) |=> (level_reg == '0 && !mis_reg && !ovf_reg && out_valid_reg))
        else $error("string state not cleared after last byte");

    a_frozen_after_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        (mis_reg && !(take && cmd.last)) |=> $stable(level_reg))
        else $error("stack moved after mismatch");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

### hdl/bracket_balance_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Balanced-bracket checker. Each input transaction carries one byte and a
// last_char flag; '(' '[' '{' push, ')' ']' '}' pop when the top matches,
// any other byte is ignored. The byte flagged last_char produces one result
// transaction (balanced, overflowed) and clears the string state; all other
// bytes produce none. A closer on an empty stack or against the wrong
// opener marks the string unbalanced and freezes the stack until the end of
// the string. A push beyond STACK_DEPTH is dropped, sets overflowed and
// marks the string unbalanced. Throughput is one byte per clock sustained
// while out_stall is low, with any mix of pushes and pops: the two top
// stack entries sit in registers and the stack RAM is read ahead at the
// entry a pop would need. An accepted last byte reaches its result
// through the front register, a queue slot and the result register, in
// that order. No reset sweep is needed; stack RAM data is only used below
// the current level.
module bracket_balance_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire bbc_pkg::in_item_t  in_data,
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      bbc_pkg::out_item_t out_data
);

    import bbc_pkg::*;

    // front -> queue
    logic fq_valid;
    logic fq_ready;
    cmd_t fq_cmd;

    // queue -> back
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_cmd;

    // Front: input register and byte classification
    bbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    // Short command queue decoupling front and back
    bbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    // Back: stack, sticky flags and result register
    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### verif/tb_bracket_balance_checker.sv
`timescale 1ns / 1ps

// Testbench for bracket_balance_checker.
//
// Input side: one byte per transaction, last_char marks the end of a string.
// Output side: one (balanced, overflowed) transaction per string.
// Both sides use valid/stall: a transaction moves on a rising edge where
// valid is high and stall is low.
//
// Flow:
//   1. Reset, then a short table of directed strings. Rows whose answer is
//      obvious (empty-stack closer, lone zero and all-ones bytes, simple
//      pairs, wrong closer, unclosed opener) carry the expected result
//      inline; the rest go through the predictor.
//   2. One string nested exactly to the stack depth and one past it.
//   3. Random strings: mostly properly nested with noise bytes mixed in, a
//      share of them broken by one edit, some pure noise, and now and then
//      a deep one that runs into the stack limit.
//   4. In the middle, a burst of one-byte strings while the receiver holds
//      off for a long stretch, so the command queue fills and the block
//      stalls its input.
// Sender gaps and receiver stalls rotate through four idle profiles.
module tb_bracket_balance_checker;

    import bbc_pkg::*;

    localparam int STACK_DEPTH     = 64;
    localparam int TOTAL_ITEMS     = 1400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PRESSURE_AT     = 40;     // string index where the hold-off starts
    localparam int DRAIN_CYCLES    = 12;     // pipeline is 3 deep; leave margin
    localparam int CYCLE_LIMIT     = 200000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    bracket_balance_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shared knobs between the sender, the receiver and the main sequence
    // ------------------------------------------------------------------
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit hold_off_req       = 1'b0;
    int mismatch_count     = 0;
    int cycle_count        = 0;

    // Results still owed by the block, oldest first
    out_item_t owed_results[$];

    // Bytes of the string currently being sent
    in_item_t string_chars[$];

    // ------------------------------------------------------------------
    // Bracket stack predictor: its own copy of the per-string state
    // ------------------------------------------------------------------
    logic [1:0] nest_kinds[STACK_DEPTH];
    int         nest_level;
    bit         crossed_seen;    // sticky: closer on empty stack or wrong kind
    bit         overrun_seen;    // sticky: push attempted on a full stack

    function automatic void clear_nesting();
        nest_level   = 0;
        crossed_seen = 1'b0;
        overrun_seen = 1'b0;
    endfunction

    // Advances the predictor by one byte. Returns 1 and fills verdict when
    // the byte ends a string.
    function automatic bit track_nesting(input in_item_t item, output out_item_t verdict);
        bit         is_open;
        bit         is_close;
        logic [1:0] kind;
        is_open  = 1'b0;
        is_close = 1'b0;
        kind     = BR_PAREN;
        verdict  = '0;
        case (item.char_code)
            CHAR_LPAREN: begin is_open  = 1'b1; kind = BR_PAREN;  end
            CHAR_LSQ:    begin is_open  = 1'b1; kind = BR_SQUARE; end
            CHAR_LCURLY: begin is_open  = 1'b1; kind = BR_CURLY;  end
            CHAR_RPAREN: begin is_close = 1'b1; kind = BR_PAREN;  end
            CHAR_RSQ:    begin is_close = 1'b1; kind = BR_SQUARE; end
            CHAR_RCURLY: begin is_close = 1'b1; kind = BR_CURLY;  end
            default: ;
        endcase
        // once crossed, the stack is frozen until the string ends
        if (!crossed_seen)
        begin
            if (is_open)
            begin
                if (nest_level >= STACK_DEPTH)
                    overrun_seen = 1'b1;
                else
                begin
                    nest_kinds[nest_level] = kind;
                    nest_level++;
                end
            end
            else if (is_close)
            begin
                if (nest_level == 0 || nest_kinds[nest_level - 1] != kind)
                    crossed_seen = 1'b1;
                else
                    nest_level--;
            end
        end
        if (!item.last_char)
            return 1'b0;
        verdict.balanced   = !crossed_seen && !overrun_seen && nest_level == 0;
        verdict.overflowed = overrun_seen;
        clear_nesting();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        // keep the log bounded if everything goes wrong
        if (mismatch_count <= 100)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Input driver: optional idle gap, then hold the transaction until it
    // is taken. Prediction happens at the accepting edge.
    // ------------------------------------------------------------------
    task automatic send_char(input in_item_t item, input bit pinned, input out_item_t pinned_result);
        out_item_t predicted;
        bit        ends_string;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ends_string = track_nesting(item, predicted);
        if (ends_string)
            owed_results.push_back(pinned ? pinned_result : predicted);
    endtask

    // Sends string_chars; returns how many bytes went out
    task automatic send_string(output int work_items);
        in_item_t c;
        work_items = 0;
        foreach (string_chars[i])
        begin
            c = string_chars[i];
            send_char(c, 1'b0, '0);
            work_items++;
        end
    endtask

    // ------------------------------------------------------------------
    // String composition
    // ------------------------------------------------------------------
    function automatic logic [7:0] opener_char(input logic [1:0] kind);
        case (kind)
            BR_PAREN:  return CHAR_LPAREN;
            BR_SQUARE: return CHAR_LSQ;
            default:   return CHAR_LCURLY;
        endcase
    endfunction

    function automatic logic [7:0] closer_char(input logic [1:0] kind);
        case (kind)
            BR_PAREN:  return CHAR_RPAREN;
            BR_SQUARE: return CHAR_RSQ;
            default:   return CHAR_RCURLY;
        endcase
    endfunction

    function automatic logic [7:0] any_bracket();
        logic [1:0] kind;
        kind = 2'($urandom_range(0, 2));
        return $urandom_range(0, 1) ? opener_char(kind) : closer_char(kind);
    endfunction

    function automatic void append_char(input logic [7:0] c);
        in_item_t item;
        item.char_code = c;
        item.last_char = 1'b0;
        string_chars.push_back(item);
    endfunction

    // forced_depth > 0: strictly nested string of exactly that depth.
    // Otherwise a random shape: nested with noise, nested then damaged by
    // one edit, pure noise, or (rarely) deep enough that it may hit the stack limit.
    function automatic void compose_string(input int forced_depth);
        logic [1:0] open_kinds[$];
        logic [1:0] kind;
        in_item_t   item;
        int         shape;
        int         max_nest;
        int         len;
        int         pick;
        int         idx;
        string_chars.delete();
        shape = $urandom_range(0, 39);
        if (forced_depth > 0 || shape == 39)
        begin
            max_nest = (forced_depth > 0) ? forced_depth : $urandom_range(60, 68);
            repeat (max_nest)
            begin
                kind = 2'($urandom_range(0, 2));
                open_kinds.push_back(kind);
                append_char(opener_char(kind));
            end
            while (open_kinds.size() > 0)
                append_char(closer_char(open_kinds.pop_back()));
        end
        else if (shape < 34)
        begin
            max_nest = $urandom_range(1, 8);
            len      = $urandom_range(1, 16);
            repeat (len)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4 && open_kinds.size() < max_nest)
                begin
                    kind = 2'($urandom_range(0, 2));
                    open_kinds.push_back(kind);
                    append_char(opener_char(kind));
                end
                else if (pick < 8 && open_kinds.size() > 0)
                    append_char(closer_char(open_kinds.pop_back()));
                else
                    append_char(8'($urandom_range(0, 255)));
            end
            while (open_kinds.size() > 0)
                append_char(closer_char(open_kinds.pop_back()));
            // damage one byte: swap in a random bracket or drop it
            if (shape >= 26)
            begin
                idx = $urandom_range(0, string_chars.size() - 1);
                if ($urandom_range(0, 1))
                begin
                    item           = string_chars[idx];
                    item.char_code = any_bracket();
                    string_chars[idx] = item;
                end
                else
                    string_chars.delete(idx);
            end
        end
        else
        begin
            len = $urandom_range(1, 8);
            repeat (len)
                append_char($urandom_range(0, 1) ? any_bracket() : 8'($urandom_range(0, 255)));
        end
        if (string_chars.size() == 0)
            append_char(8'($urandom_range(0, 255)));
        item           = string_chars[string_chars.size() - 1];
        item.last_char = 1'b1;
        string_chars[string_chars.size() - 1] = item;
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        in_item_t  item;
        bit        pinned;     // expected result given inline
        out_item_t result;
    } directed_row_t;

    directed_row_t directed_rows[$];

    function automatic void add_row(input logic [7:0] c, input bit last,
                                    input bit pinned, input bit bal, input bit ovf);
        directed_row_t row;
        row.item.char_code = c;
        row.item.last_char = last;
        row.pinned         = pinned;
        row.result.balanced   = bal;
        row.result.overflowed = ovf;
        directed_rows.push_back(row);
    endfunction

    function automatic void build_directed_table();
        // closer straight after reset: empty-stack mismatch
        add_row(CHAR_RPAREN, 1'b1, 1'b1, 1'b0, 1'b0);
        // zero byte and all-ones byte are plain characters
        add_row(8'h00,       1'b1, 1'b1, 1'b1, 1'b0);
        add_row(8'hFF,       1'b1, 1'b1, 1'b1, 1'b0);
        // each bracket kind closing properly
        add_row(CHAR_LPAREN, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(CHAR_RPAREN, 1'b1, 1'b1, 1'b1, 1'b0);
        add_row(CHAR_LSQ,    1'b0, 1'b0, 1'b0, 1'b0);
        add_row(CHAR_RSQ,    1'b1, 1'b1, 1'b1, 1'b0);
        add_row(CHAR_LCURLY, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(8'h41,       1'b0, 1'b0, 1'b0, 1'b0);
        add_row(CHAR_RCURLY, 1'b1, 1'b1, 1'b1, 1'b0);
        // wrong closer against the top
        add_row(CHAR_LPAREN, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(CHAR_RSQ,    1'b1, 1'b1, 1'b0, 1'b0);
        // interleaved kinds
        add_row(CHAR_LCURLY, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(CHAR_LSQ,    1'b0, 1'b0, 1'b0, 1'b0);
        add_row(CHAR_RCURLY, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(CHAR_RSQ,    1'b1, 1'b0, 1'b0, 1'b0);
        // early mismatch freezes the stack; later pair does not repair it
        add_row(CHAR_RPAREN, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(CHAR_LPAREN, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(CHAR_RPAREN, 1'b1, 1'b1, 1'b0, 1'b0);
        // opener left open at the end
        add_row(CHAR_LSQ,    1'b1, 1'b1, 1'b0, 1'b0);
        // state really cleared: a fresh pair balances again
        add_row(CHAR_LCURLY, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(CHAR_RCURLY, 1'b1, 1'b1, 1'b1, 1'b0);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls per the current profile, plus a long
    // hold-off on request, counted here in its own cycles.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_results.size() == 0)
                report_mismatch($sformatf("unexpected result balanced=%0b overflowed=%0b",
                                          out_data.balanced, out_data.overflowed));
            else
            begin
                want = owed_results.pop_front();
                if (out_data.balanced !== want.balanced)
                    report_mismatch($sformatf("balanced got %0b want %0b",
                                              out_data.balanced, want.balanced));
                if (out_data.overflowed !== want.overflowed)
                    report_mismatch($sformatf("overflowed got %0b want %0b",
                                              out_data.overflowed, want.overflowed));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int       work_done;
        int       work_items;
        int       strings_done;
        in_item_t burst_item;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        clear_nesting();
        build_directed_table();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        foreach (directed_rows[i])
            send_char(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].result);
        work_done = directed_rows.size();

        // full-depth nesting, then one level past the stack
        compose_string(STACK_DEPTH);
        send_string(work_items);
        work_done += work_items;
        compose_string(STACK_DEPTH + 1);
        send_string(work_items);
        work_done += work_items;

        strings_done = 0;
        while (work_done < TOTAL_ITEMS)
        begin
            // rotate idle profiles every ten strings
            case ((strings_done / 10) % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
                default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
            endcase

            if (strings_done == PRESSURE_AT)
            begin
                // back-to-back one-byte strings against a blocked receiver
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
                hold_off_req       = 1'b1;
                repeat (40)
                begin
                    burst_item.char_code = $urandom_range(0, 1) ? any_bracket()
                                                                : 8'($urandom_range(0, 255));
                    burst_item.last_char = 1'b1;
                    send_char(burst_item, 1'b0, '0);
                    work_done++;
                end
            end

            compose_string(0);
            send_string(work_items);
            work_done += work_items;
            strings_done++;
        end
        in_valid <= 1'b0;

        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && owed_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
hdl/bbc_pkg.sv
hdl/bbc_ram.sv
hdl/bbc_front.sv
hdl/bbc_queue.sv
hdl/bbc_back.sv
hdl/bracket_balance_checker.sv
verif/tb_bracket_balance_checker.sv
